// ===== hdl/irdet_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the imu rest detector
package irdet_pkg;

   localparam int MODE_W     = 2;
   localparam int DT_W       = 24;
   localparam int TIMER_W    = 32;
   localparam int THR_W      = 16;
   localparam int CLIP_W     = 15;
   localparam int FSQ_W      = 2 * THR_W;
   localparam int CHUNK_W    = 32;
   localparam int CHUNK_SH   = $clog2(CHUNK_W);
   localparam int MAX_CHUNKS = 2;
   localparam int NORM_W     = CHUNK_W * MAX_CHUNKS;
   localparam int NUM_AXES   = 3;
   localparam int IDX_W      = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int RSP_W      = 40;

   localparam logic [MODE_W-1:0] MODE_GYRO  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ACCEL = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MAG   = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_GYRO_THR  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_GYRO_CLIP = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ACC_THR   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAG_FRAC  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_REST  = 3'd4;

   localparam logic [THR_W-1:0]   GYRO_THR_RST  = 16'd200;
   localparam logic [CLIP_W-1:0]  GYRO_CLIP_RST = 15'd1000;
   localparam logic [THR_W-1:0]   ACC_THR_RST   = 16'd400;
   localparam logic [THR_W-1:0]   MAG_FRAC_RST  = 16'd6554;
   localparam logic [TIMER_W-1:0] MIN_REST_RST  = 32'd1500000;

   typedef enum logic [1:0] {
      ACC_DEV,
      ACC_NORM,
      ACC_FSQ,
      ACC_CMP
   } acc_sel_type;

   typedef enum logic [1:0] {
      OPD_DIFF,
      OPD_LAST,
      OPD_THR,
      OPD_SCALE
   } opd_sel_type;

   typedef struct packed {
      logic              clear;
      logic              en;
      acc_sel_type       dest;
      opd_sel_type       opd;
      logic [IDX_W-1:0]  idx;
   } mac_ctl_type;

endpackage

// ===== hdl/irdet_mac.sv =====
`timescale 1ns / 1ps
// shared multiply-accumulate unit with its accumulator bank
module irdet_mac #(
   parameter int MUL_W = 32,
   parameter int ACC_W = 66
) (
   input  logic                   clock,
   input  irdet_pkg::mac_ctl_type ctl,
   input  logic [MUL_W-1:0]       opd_a,
   input  logic [MUL_W-1:0]       opd_b,
   output logic [ACC_W-1:0]       dev,
   output logic [ACC_W-1:0]       norm,
   output logic [ACC_W-1:0]       fsq,
   output logic [ACC_W-1:0]       cmp
);

   localparam int PROD_W = 2 * MUL_W;
   localparam int SH_W   = irdet_pkg::IDX_W + irdet_pkg::CHUNK_SH;

   logic [PROD_W-1:0] prod;
   logic [SH_W-1:0]   shamt;
   logic [ACC_W-1:0]  term;
   logic [ACC_W-1:0]  cur;
   logic [ACC_W-1:0]  sum;
   logic [ACC_W-1:0]  dev_ff, dev_in;
   logic [ACC_W-1:0]  norm_ff, norm_in;
   logic [ACC_W-1:0]  fsq_ff, fsq_in;
   logic [ACC_W-1:0]  cmp_ff, cmp_in;

   always_comb begin
      prod = PROD_W'(opd_a) * PROD_W'(opd_b);
      // partial products of a long operand land one chunk higher each step
      if (ctl.opd == irdet_pkg::OPD_SCALE) begin
         shamt = SH_W'(ctl.idx) << irdet_pkg::CHUNK_SH;
      end else begin
         shamt = '0;
      end
      term = ACC_W'(prod) << shamt;
      unique case (ctl.dest)
         irdet_pkg::ACC_DEV:  cur = dev_ff;
         irdet_pkg::ACC_NORM: cur = norm_ff;
         irdet_pkg::ACC_FSQ:  cur = fsq_ff;
         irdet_pkg::ACC_CMP:  cur = cmp_ff;
      endcase
      sum = cur + term;

      dev_in  = dev_ff;
      norm_in = norm_ff;
      fsq_in  = fsq_ff;
      cmp_in  = cmp_ff;
      if (ctl.clear) begin
         dev_in  = '0;
         norm_in = '0;
         fsq_in  = '0;
         cmp_in  = '0;
      end else if (ctl.en) begin
         unique case (ctl.dest)
            irdet_pkg::ACC_DEV:  dev_in  = sum;
            irdet_pkg::ACC_NORM: norm_in = sum;
            irdet_pkg::ACC_FSQ:  fsq_in  = sum;
            irdet_pkg::ACC_CMP:  cmp_in  = sum;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      dev_ff  <= dev_in;
      norm_ff <= norm_in;
      fsq_ff  <= fsq_in;
      cmp_ff  <= cmp_in;
   end

   assign dev  = dev_ff;
   assign norm = norm_ff;
   assign fsq  = fsq_ff;
   assign cmp  = cmp_ff;

endmodule

// ===== hdl/irdet_ctrl.sv =====
`timescale 1ns / 1ps
// sequencer that steps the shared multiply-accumulate unit through one request
module irdet_ctrl #(
   parameter int NUM_CHUNKS = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   skip,
   input  logic                   is_mag,
   input  logic                   out_free,
   output logic                   idle,
   output logic                   decide,
   output irdet_pkg::mac_ctl_type ctl
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_DEV   = 6'b000010,
      ST_NORM  = 6'b000100,
      ST_THR   = 6'b001000,
      ST_SCALE = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   localparam logic [irdet_pkg::IDX_W-1:0] AXIS_LAST  = irdet_pkg::IDX_W'(irdet_pkg::NUM_AXES - 1);
   localparam logic [irdet_pkg::IDX_W-1:0] CHUNK_LAST = irdet_pkg::IDX_W'(NUM_CHUNKS - 1);

   state_type                    state_ff, state_in;
   logic [irdet_pkg::IDX_W-1:0]  cnt_ff, cnt_in;
   logic                         mag_ff, mag_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      mag_in    = mag_ff;
      idle      = 1'b0;
      decide    = 1'b0;
      ctl.clear = 1'b0;
      ctl.en    = 1'b0;
      ctl.dest  = irdet_pkg::ACC_DEV;
      ctl.opd   = irdet_pkg::OPD_DIFF;
      ctl.idx   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            idle = 1'b1;
            if (start) begin
               mag_in    = is_mag;
               cnt_in    = '0;
               ctl.clear = 1'b1;
               if (skip) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_DEV;
               end
            end
         end
         ST_DEV: begin
            ctl.en   = 1'b1;
            ctl.dest = irdet_pkg::ACC_DEV;
            ctl.opd  = irdet_pkg::OPD_DIFF;
            if (cnt_ff == AXIS_LAST) begin
               cnt_in = '0;
               if (mag_ff) begin
                  state_in = ST_NORM;
               end else begin
                  state_in = ST_THR;
               end
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_NORM: begin
            ctl.en   = 1'b1;
            ctl.dest = irdet_pkg::ACC_NORM;
            ctl.opd  = irdet_pkg::OPD_LAST;
            if (cnt_ff == AXIS_LAST) begin
               cnt_in   = '0;
               state_in = ST_THR;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_THR: begin
            ctl.en  = 1'b1;
            ctl.opd = irdet_pkg::OPD_THR;
            cnt_in  = '0;
            if (mag_ff) begin
               ctl.dest = irdet_pkg::ACC_FSQ;
               state_in = ST_SCALE;
            end else begin
               ctl.dest = irdet_pkg::ACC_CMP;
               state_in = ST_DONE;
            end
         end
         ST_SCALE: begin
            ctl.en   = 1'b1;
            ctl.dest = irdet_pkg::ACC_CMP;
            ctl.opd  = irdet_pkg::OPD_SCALE;
            if (cnt_ff == CHUNK_LAST) begin
               cnt_in   = '0;
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               decide   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         mag_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         mag_ff   <= mag_in;
      end
   end

endmodule

// ===== hdl/imu_rest_detector_core.sv =====
`timescale 1ns / 1ps
// imu rest detector top level: sample store, rest timer and decision logic
//
// channel  dir  signal  width                        contents (low bits first)
// req      in   tdata   24+3*SAMPLE_BITS, byte pad   dt_micros, axis_x, axis_y, axis_z
// req      in   tuser   2                            mode
// rsp      out  tdata   40                           rest_detected, rest_time_us
// csr      in   write   addr 3, data 32              five write-only registers
//
// one multiply-accumulate per cycle sets the pace: gyro and accel requests take a
// deviation step per axis and a threshold step, mag requests add a norm step per
// axis and a scale step per 32-bit chunk of the norm; ignored ones skip to the end
// synchronous reset clears the sequencer, stored samples, timer and flag and
// loads the register defaults; no clearing pass
// a finished result waits in the output register while the next request is taken;
// the sequencer holds in its last step only while that register is still full
module imu_rest_detector_core #(
   parameter  int SAMPLE_BITS = 16,
   localparam int REQ_W = ((irdet_pkg::DT_W + 3 * SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [REQ_W-1:0]                 req_tdata,  // dt_micros, axis_x, axis_y, axis_z
   input  logic [irdet_pkg::MODE_W-1:0]     req_tuser,  // mode
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [irdet_pkg::RSP_W-1:0]      rsp_tdata,  // rest_detected, rest_time_us
   input  logic                             csr_we,
   input  logic [irdet_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [irdet_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int SB         = SAMPLE_BITS;
   localparam int MUL_W      = (SB > irdet_pkg::CHUNK_W) ? SB : irdet_pkg::CHUNK_W;
   localparam int ACC_W      = 2 * SB + 2 + irdet_pkg::FSQ_W;
   localparam int NUM_CHUNKS = (2 * SB + irdet_pkg::CHUNK_W - 1) / irdet_pkg::CHUNK_W;
   localparam int CLIP_CMP_W = (SB > irdet_pkg::CLIP_W) ? SB : irdet_pkg::CLIP_W;
   localparam int DEV_TOP    = ACC_W - irdet_pkg::FSQ_W;
   localparam int TW         = irdet_pkg::TIMER_W;
   localparam int NA         = irdet_pkg::NUM_AXES;

   // configuration registers
   logic [irdet_pkg::THR_W-1:0]  gyro_thr_ff, gyro_thr_in;
   logic [irdet_pkg::CLIP_W-1:0] gyro_clip_ff, gyro_clip_in;
   logic [irdet_pkg::THR_W-1:0]  acc_thr_ff, acc_thr_in;
   logic [irdet_pkg::THR_W-1:0]  mag_frac_ff, mag_frac_in;
   logic [TW-1:0]                min_rest_ff, min_rest_in;

   // current request
   logic [irdet_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [irdet_pkg::DT_W-1:0]   dt_ff, dt_in;
   logic [SB-1:0]                axis_ff [NA];
   logic [SB-1:0]                axis_in [NA];
   logic                         skip_ff, skip_in;

   // detector state
   logic [SB-1:0]                last_gyro_ff  [NA];
   logic [SB-1:0]                last_gyro_in  [NA];
   logic [SB-1:0]                last_accel_ff [NA];
   logic [SB-1:0]                last_accel_in [NA];
   logic [SB-1:0]                last_mag_ff   [NA];
   logic [SB-1:0]                last_mag_in   [NA];
   logic [TW-1:0]                timer_ff, timer_in;
   logic                         flag_ff, flag_in;

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [TW-1:0]                rsp_timer_ff, rsp_timer_in;
   logic                         rsp_flag_ff, rsp_flag_in;

   logic                         accept;
   logic [SB-1:0]                req_axis [NA];
   logic                         req_zero;
   logic                         req_skip;
   logic                         idle;
   logic                         decide;
   logic                         out_free;
   irdet_pkg::mac_ctl_type       ctl;

   logic [MUL_W-1:0]             opd_a, opd_b;
   logic [ACC_W-1:0]             dev, norm, fsq, cmp;

   logic [SB-1:0]                sel_cur, sel_last, sel_mag;
   logic [SB:0]                  diff, diff_neg, mag_ext;
   logic [SB-1:0]                diff_abs, mag_abs;
   logic [irdet_pkg::THR_W-1:0]  thr_sel;
   logic [irdet_pkg::NORM_W-1:0] norm_pad;
   logic [irdet_pkg::CHUNK_SH:0] chunk_base;
   logic [irdet_pkg::CHUNK_W-1:0] norm_chunk;

   logic [SB:0]                  gyro_ext [NA];
   logic [SB-1:0]                gyro_abs [NA];
   logic                         gyro_clip;
   logic                         dev_ge, mag_ge, trip;
   logic [ACC_W-1:0]             dev_scaled;
   logic [TW:0]                  timer_sum;
   logic [TW-1:0]                timer_sat;

   assign accept     = req_tvalid & req_tready;
   assign req_tready = idle;
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   // request unpacking and the ignore rule
   always_comb begin
      for (int i = 0; i < NA; i++) begin
         req_axis[i] = req_tdata[irdet_pkg::DT_W + i * SB +: SB];
      end
      req_zero = (req_axis[0] == '0) && (req_axis[1] == '0) && (req_axis[2] == '0);
      case (req_tuser) inside
         irdet_pkg::MODE_GYRO:                       req_skip = 1'b0;
         irdet_pkg::MODE_ACCEL, irdet_pkg::MODE_MAG: req_skip = req_zero;
         default:                                    req_skip = 1'b1;
      endcase
   end

   always_comb begin
      mode_in = mode_ff;
      dt_in   = dt_ff;
      skip_in = skip_ff;
      axis_in = axis_ff;
      if (accept) begin
         mode_in = req_tuser;
         dt_in   = req_tdata[irdet_pkg::DT_W-1:0];
         skip_in = req_skip;
         axis_in = req_axis;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      dt_ff   <= dt_in;
      skip_ff <= skip_in;
      axis_ff <= axis_in;
   end

   // configuration writes
   always_comb begin
      gyro_thr_in  = gyro_thr_ff;
      gyro_clip_in = gyro_clip_ff;
      acc_thr_in   = acc_thr_ff;
      mag_frac_in  = mag_frac_ff;
      min_rest_in  = min_rest_ff;
      if (csr_we) begin
         unique case (csr_addr)
            irdet_pkg::CSR_GYRO_THR:  gyro_thr_in  = csr_wdata[irdet_pkg::THR_W-1:0];
            irdet_pkg::CSR_GYRO_CLIP: gyro_clip_in = csr_wdata[irdet_pkg::CLIP_W-1:0];
            irdet_pkg::CSR_ACC_THR:   acc_thr_in   = csr_wdata[irdet_pkg::THR_W-1:0];
            irdet_pkg::CSR_MAG_FRAC:  mag_frac_in  = csr_wdata[irdet_pkg::THR_W-1:0];
            irdet_pkg::CSR_MIN_REST:  min_rest_in  = csr_wdata[TW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gyro_thr_ff  <= irdet_pkg::GYRO_THR_RST;
         gyro_clip_ff <= irdet_pkg::GYRO_CLIP_RST;
         acc_thr_ff   <= irdet_pkg::ACC_THR_RST;
         mag_frac_ff  <= irdet_pkg::MAG_FRAC_RST;
         min_rest_ff  <= irdet_pkg::MIN_REST_RST;
      end else begin
         gyro_thr_ff  <= gyro_thr_in;
         gyro_clip_ff <= gyro_clip_in;
         acc_thr_ff   <= acc_thr_in;
         mag_frac_ff  <= mag_frac_in;
         min_rest_ff  <= min_rest_in;
      end
   end

   // operand selection for the shared unit
   always_comb begin
      sel_cur = axis_ff[ctl.idx];
      case (mode_ff)
         irdet_pkg::MODE_GYRO: begin
            sel_last = last_gyro_ff[ctl.idx];
            thr_sel  = gyro_thr_ff;
         end
         irdet_pkg::MODE_ACCEL: begin
            sel_last = last_accel_ff[ctl.idx];
            thr_sel  = acc_thr_ff;
         end
         default: begin
            sel_last = last_mag_ff[ctl.idx];
            thr_sel  = mag_frac_ff;
         end
      endcase
      sel_mag  = last_mag_ff[ctl.idx];
      diff     = {sel_cur[SB-1], sel_cur} - {sel_last[SB-1], sel_last};
      diff_neg = ~diff + 1'b1;
      diff_abs = diff[SB] ? diff_neg[SB-1:0] : diff[SB-1:0];
      mag_ext  = {sel_mag[SB-1], sel_mag};
      mag_ext  = mag_ext[SB] ? (~mag_ext + 1'b1) : mag_ext;
      mag_abs  = mag_ext[SB-1:0];

      norm_pad   = irdet_pkg::NORM_W'(norm);
      chunk_base = {ctl.idx[0], {irdet_pkg::CHUNK_SH{1'b0}}};
      norm_chunk = norm_pad[chunk_base +: irdet_pkg::CHUNK_W];

      unique case (ctl.opd)
         irdet_pkg::OPD_DIFF: begin
            opd_a = MUL_W'(diff_abs);
            opd_b = MUL_W'(diff_abs);
         end
         irdet_pkg::OPD_LAST: begin
            opd_a = MUL_W'(mag_abs);
            opd_b = MUL_W'(mag_abs);
         end
         irdet_pkg::OPD_THR: begin
            opd_a = MUL_W'(thr_sel);
            opd_b = MUL_W'(thr_sel);
         end
         irdet_pkg::OPD_SCALE: begin
            opd_a = MUL_W'(fsq[irdet_pkg::FSQ_W-1:0]);
            opd_b = MUL_W'(norm_chunk);
         end
      endcase
   end

   irdet_mac #(
      .MUL_W (MUL_W),
      .ACC_W (ACC_W)
   ) u_mac (
      .clock (clock),
      .ctl   (ctl),
      .opd_a (opd_a),
      .opd_b (opd_b),
      .dev   (dev),
      .norm  (norm),
      .fsq   (fsq),
      .cmp   (cmp)
   );

   irdet_ctrl #(
      .NUM_CHUNKS (NUM_CHUNKS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .skip     (req_skip),
      .is_mag   (req_tuser == irdet_pkg::MODE_MAG),
      .out_free (out_free),
      .idle     (idle),
      .decide   (decide),
      .ctl      (ctl)
   );

   // rest decision
   always_comb begin
      gyro_clip = 1'b0;
      for (int i = 0; i < NA; i++) begin
         gyro_ext[i] = {last_gyro_ff[i][SB-1], last_gyro_ff[i]};
         gyro_ext[i] = gyro_ext[i][SB] ? (~gyro_ext[i] + 1'b1) : gyro_ext[i];
         gyro_abs[i] = gyro_ext[i][SB-1:0];
         if (CLIP_CMP_W'(gyro_abs[i]) > CLIP_CMP_W'(gyro_clip_ff)) begin
            gyro_clip = 1'b1;
         end
      end
      dev_ge     = dev >= cmp;
      // mag deviation is compared against frac^2 * norm, frac^2 in Q0.32
      dev_scaled = {dev[DEV_TOP-1:0], {irdet_pkg::FSQ_W{1'b0}}};
      mag_ge     = dev_scaled >= cmp;
      timer_sum  = {1'b0, timer_ff} + (TW + 1)'(dt_ff);
      timer_sat  = timer_sum[TW] ? {TW{1'b1}} : timer_sum[TW-1:0];

      case (mode_ff)
         irdet_pkg::MODE_GYRO:  trip = dev_ge | gyro_clip;
         irdet_pkg::MODE_ACCEL: trip = dev_ge;
         irdet_pkg::MODE_MAG:   trip = mag_ge;
         default:               trip = 1'b0;
      endcase

      timer_in      = timer_ff;
      flag_in       = flag_ff;
      last_gyro_in  = last_gyro_ff;
      last_accel_in = last_accel_ff;
      last_mag_in   = last_mag_ff;
      if (decide && !skip_ff) begin
         if (trip) begin
            timer_in = '0;
            flag_in  = 1'b0;
         end else if (mode_ff == irdet_pkg::MODE_ACCEL) begin
            timer_in = timer_sat;
            if (timer_sat >= min_rest_ff) begin
               flag_in = 1'b1;
            end
         end
         case (mode_ff)
            irdet_pkg::MODE_GYRO:  last_gyro_in  = axis_ff;
            irdet_pkg::MODE_ACCEL: last_accel_in = axis_ff;
            irdet_pkg::MODE_MAG:   last_mag_in   = axis_ff;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff <= '0;
         flag_ff  <= 1'b0;
         for (int i = 0; i < NA; i++) begin
            last_gyro_ff[i]  <= '0;
            last_accel_ff[i] <= '0;
            last_mag_ff[i]   <= '0;
         end
      end else begin
         timer_ff      <= timer_in;
         flag_ff       <= flag_in;
         last_gyro_ff  <= last_gyro_in;
         last_accel_ff <= last_accel_in;
         last_mag_ff   <= last_mag_in;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_timer_in = rsp_timer_ff;
      rsp_flag_in  = rsp_flag_ff;
      if (decide) begin
         rsp_valid_in = 1'b1;
         rsp_timer_in = timer_in;
         rsp_flag_in  = flag_in;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_timer_ff <= rsp_timer_in;
      rsp_flag_ff  <= rsp_flag_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = irdet_pkg::RSP_W'({rsp_timer_ff, rsp_flag_ff});

endmodule

// ===== hdl/irdet_checker.sv =====
`timescale 1ns / 1ps
// port-level checks of the imu rest detector and their binding
module irdet_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [irdet_pkg::RSP_W-1:0] rsp_tdata
);

   // after reset the block is empty and ready
   a_reset_state: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("not idle after reset");

   // one request at a time: ready drops right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while busy");

   // a new result only comes out of the final sequencer step
   a_result_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared without a request in progress");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule

bind imu_rest_detector_core irdet_checker u_irdet_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
